// File: rtl/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg: shared types and constants for the integer printf formatter
// Verb codes, character constants and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int MaxWidth    = 64;
  localparam int ResultSlots = 64;
  localparam int WidthCap    = (MaxWidth < ResultSlots) ? MaxWidth : ResultSlots;
  localparam int DigW        = 7;   // digit count, up to 64

  // ceil(2^23 / 10); exact quotient for any dividend below 2^22
  localparam logic [19:0] Recip10 = 20'hCCCCD;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_OCT  = 3'd4;
  localparam logic [2:0] OP_BIN  = 3'd5;
  localparam logic [2:0] OP_CHAR = 3'd6;
  localparam logic [2:0] OP_PTR  = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic       load;       // capture a new request
    logic       div_step;   // one division step (decimal)
    logic       div_start;  // start a new division on the working value
    logic       push;       // push the digit just produced
    logic       shift_out;  // base 2^k digit push
    logic       pop;        // pop one digit
  } ipf_cmd_t;

  typedef struct packed {
    logic            div_done;
    logic            val_zero;
    logic [DigW-1:0] ndig;
    logic            neg;
  } ipf_sts_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
    else c = 8'h61 + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

// File: rtl/ipf_if.sv
// ----------------------------------------------------------------------------
// ipf_req_if / ipf_chr_if: valid/ready channels of the formatter
// Request word in, one character word out.
// ----------------------------------------------------------------------------
interface ipf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [63:0] value;
  logic        is_wide;
  logic        left_align;
  logic        force_plus;
  logic        zero_fill;
  logic        space_sign;
  logic [6:0]  field_width;
  modport source (output valid, opcode, value, is_wide, left_align, force_plus,
                  zero_fill, space_sign, field_width, input ready);
  modport sink (input valid, opcode, value, is_wide, left_align, force_plus,
                zero_fill, space_sign, field_width, output ready);
endinterface

interface ipf_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;
  modport source (output valid, out_char, is_last, input ready);
  modport sink (input valid, out_char, is_last, output ready);
endinterface

// File: rtl/integer_printf_formatter.sv
// ----------------------------------------------------------------------------
// integer_printf_formatter: printf-style integer field generator
// Flow: a request is loaded, then converted to digits (decimal: start, four
// 16-bit divide steps, push per digit; else one shift per digit), then emitted.
// Throughput: one word per cycle while the receiver is ready; empty pad phases
// are skipped without a word; next request taken once is_last is presented.
// Reset: synchronous active low, clears sequencer and output valid.
// ----------------------------------------------------------------------------
module integer_printf_formatter (
  input logic       clk,
  input logic       rst_n,
  ipf_req_if.sink   in_req,
  ipf_chr_if.source out_chr
);
  import ipf_pkg::*;

  ipf_cmd_t   cmd;
  ipf_sts_t   sts;
  logic [3:0] top_digit;

  ipf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .chr       (out_chr),
    .cmd       (cmd),
    .sts       (sts),
    .top_digit (top_digit)
  );

  ipf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .opcode    (in_req.opcode),
    .value     (in_req.value),
    .is_wide   (in_req.is_wide),
    .sts       (sts),
    .top_digit (top_digit)
  );
endmodule

// File: rtl/ipf_datapath.sv
// ----------------------------------------------------------------------------
// ipf_datapath: operand register, radix converter and digit stack
// Decimal divides by ten sixteen bits a step by reciprocal multiply, four
// steps a digit; power-of-two bases peel one digit a cycle. Digits go on a LIFO.
// ----------------------------------------------------------------------------
module ipf_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  ipf_pkg::ipf_cmd_t cmd,
  input  logic [2:0]      opcode,
  input  logic [63:0]     value,
  input  logic            is_wide,
  output ipf_pkg::ipf_sts_t sts,
  output logic [3:0]      top_digit
);
  import ipf_pkg::*;

  logic [63:0]     val_r, val_nxt;
  logic [63:0]     quo_r, quo_nxt;
  logic [3:0]      rem_r, rem_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic            busy_r, busy_nxt;
  logic            neg_r, neg_nxt;
  logic [DigW-1:0] ndig_r, ndig_nxt;
  logic [2:0]      op_r;
  logic [3:0]      top_r;
  logic [3:0]      stk_r [64];
  logic [63:0]     ext;
  logic [19:0]     dx;
  logic [39:0]     dprod;
  logic [15:0]     dq;
  logic [19:0]     dr;
  logic [1:0]      shamt;
  logic [3:0]      mask;
  logic [3:0]      push_d;

  always_comb begin
    ext = value;
    if (opcode == OP_SDEC && !is_wide) ext = {{32{value[31]}}, value[31:0]};
    else if (opcode != OP_PTR && !is_wide) ext = {32'd0, value[31:0]};
  end

  // bits per digit for power-of-two bases (minus one)
  always_comb begin
    unique case (op_r)
      OP_OCT:  begin shamt = 2'd2; mask = 4'h7; end
      OP_BIN:  begin shamt = 2'd0; mask = 4'h1; end
      default: begin shamt = 2'd3; mask = 4'hf; end
    endcase
  end

  // remainder so far and the next 16 bits, divided by ten
  assign dx    = {rem_r, quo_r[63:48]};
  assign dprod = {20'd0, dx} * {20'd0, Recip10};
  assign dq    = dprod[38:23];
  assign dr    = dx - ({1'b0, dq, 3'd0} + {3'd0, dq, 1'b0});

  always_comb begin
    val_nxt  = val_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    ndig_nxt = ndig_r;
    push_d   = rem_r;
    if (cmd.load) begin
      neg_nxt  = (opcode == OP_SDEC) && ext[63];
      val_nxt  = ((opcode == OP_SDEC) && ext[63]) ? (64'd0 - ext) : ext;
      ndig_nxt = '0;
      busy_nxt = 1'b0;
    end else if (cmd.div_start) begin
      quo_nxt  = val_r;
      rem_nxt  = '0;
      bit_nxt  = 3'd4;
      busy_nxt = 1'b1;
    end else if (cmd.div_step) begin
      quo_nxt = {quo_r[47:0], dq};
      rem_nxt = dr[3:0];
      bit_nxt = bit_r - 3'd1;
      if (bit_r == 3'd1) busy_nxt = 1'b0;
    end else if (cmd.push) begin
      val_nxt  = quo_r;
      ndig_nxt = ndig_r + 1'b1;
    end else if (cmd.shift_out) begin
      push_d   = val_r[3:0] & mask;
      val_nxt  = val_r >> ({5'd0, shamt} + 7'd1);
      ndig_nxt = ndig_r + 1'b1;
    end else if (cmd.pop) begin
      ndig_nxt = ndig_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ndig_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      ndig_r <= ndig_nxt;
    end
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
    if (cmd.load) op_r <= opcode;
    // top of stack kept in a register; a pop fetches the entry below
    if (cmd.push || cmd.shift_out) begin
      stk_r[ndig_r[5:0]] <= push_d;
      top_r <= push_d;
    end else if (cmd.pop) begin
      top_r <= stk_r[6'(ndig_r - 7'd2)];
    end
  end

  assign top_digit    = top_r;
  assign sts.div_done = !busy_r;
  assign sts.val_zero = (val_r == 64'd0);
  assign sts.ndig     = ndig_r;
  assign sts.neg      = neg_r;

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= 7'd64) else $error("digit stack overflow");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> busy_r && bit_r == 3'd4) else $error("divider start");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < 4'd10) else $error("remainder out of range");
`endif
endmodule

// File: rtl/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// ipf_ctrl: request sequencer
// Captures a request, drives digit conversion, then counts out padding, sign,
// prefix and digits to the output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module ipf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  ipf_req_if.sink           req,
  ipf_chr_if.source         chr,
  output ipf_pkg::ipf_cmd_t cmd,
  input  ipf_pkg::ipf_sts_t sts,
  input  logic [3:0]        top_digit
);
  import ipf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PLAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [2:0] P_LPAD  = 3'd0;
  localparam logic [2:0] P_SIGN  = 3'd1;
  localparam logic [2:0] P_ZPAD  = 3'd2;
  localparam logic [2:0] P_PFX0  = 3'd3;
  localparam logic [2:0] P_PFXX  = 3'd4;
  localparam logic [2:0] P_BODY  = 3'd5;
  localparam logic [2:0] P_RPAD  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  op_r;
  logic        left_r, plus_r, zero_r, space_r;
  logic [6:0]  width_r;
  logic [7:0]  char_r;
  logic [6:0]  pad_r, pad_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        has_sign;
  logic [7:0]  sign_ch;
  logic [6:0]  total;
  logic [6:0]  wcap;
  logic        ov_r, ov_nxt;
  logic [7:0]  och_r, och_nxt;
  logic        olast_r, olast_nxt;
  logic        slot_free;
  logic        emit;
  logic        last_cond;
  logic [2:0]  nph;

  assign slot_free = !ov_r || chr.ready;
  assign req.ready = (state_r == S_IDLE);

  assign has_sign = (op_r == OP_SDEC) && (sts.neg || plus_r || space_r);
  assign sign_ch  = sts.neg ? CH_MINUS : (plus_r ? CH_PLUS : CH_SPACE);
  assign total    = sts.ndig + {6'd0, has_sign} + ((op_r == OP_PTR) ? 7'd2 : 7'd0)
                  + ((op_r == OP_CHAR) ? 7'd1 : 7'd0);
  assign wcap     = (width_r > 7'(WidthCap)) ? 7'(WidthCap) : width_r;

  // next phase after the current one; ZPAD precedes the pointer prefix
  function automatic logic [2:0] after(input logic [2:0] p, input logic [2:0] op,
                                       input logic l, input logic hs);
    logic [2:0] n;
    unique case (p)
      P_LPAD: n = hs ? P_SIGN : P_ZPAD;
      P_SIGN: n = P_ZPAD;
      P_ZPAD: n = (op == OP_PTR) ? P_PFX0 : P_BODY;
      P_PFX0: n = P_PFXX;
      P_PFXX: n = P_BODY;
      P_BODY: n = l ? P_RPAD : P_LPAD;
      default: n = P_LPAD;
    endcase
    return n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !chr.ready;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    cmd       = '0;
    emit      = 1'b0;
    last_cond = 1'b0;
    nph       = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (op_r == OP_CHAR) begin
          state_nxt = S_PLAN;
        end else if (sts.val_zero) begin
          if (sts.ndig == '0) cmd.shift_out = 1'b1;  // lone '0'
          state_nxt = S_PLAN;
        end else if (op_r == OP_SDEC || op_r == OP_UDEC) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.shift_out = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.push  = 1'b1;
          state_nxt = S_CONV;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_PLAN: begin
        pad_nxt   = (wcap > total) ? (wcap - total) : 7'd0;
        phase_nxt = P_LPAD;
        if (left_r || zero_r) phase_nxt = has_sign ? P_SIGN : P_ZPAD;
        if (left_r && !has_sign) phase_nxt = (op_r == OP_PTR) ? P_PFX0 : P_BODY;
        cnt_nxt   = '0;
        state_nxt = S_EMIT;
      end
      default: begin
        // S_EMIT: skip empty pad phases without spending a word
        priority if ((phase_r == P_LPAD || phase_r == P_ZPAD || phase_r == P_RPAD)
                     && (cnt_r >= pad_r ||
                         (phase_r == P_ZPAD && (left_r || !zero_r)) ||
                         (phase_r == P_LPAD && zero_r))) begin
          if (phase_r == P_RPAD) begin
            state_nxt = S_IDLE;  // unreachable when a word is pending
          end else begin
            phase_nxt = after(phase_r, op_r, left_r, has_sign);
            cnt_nxt   = '0;
          end
        end else if (slot_free) begin
          emit = 1'b1;
          unique case (phase_r)
            P_SIGN:  och_nxt = sign_ch;
            P_ZPAD:  och_nxt = CH_ZERO;
            P_PFX0:  och_nxt = CH_ZERO;
            P_PFXX:  och_nxt = CH_X;
            P_BODY:  och_nxt = (op_r == OP_CHAR) ? char_r
                               : hex_char(top_digit, op_r == OP_HEXU);
            default: och_nxt = CH_SPACE;
          endcase
          cnt_nxt = cnt_r + 7'd1;
          if (phase_r == P_BODY && op_r != OP_CHAR) cmd.pop = 1'b1;
          unique case (phase_r)
            P_BODY: last_cond = (op_r == OP_CHAR || sts.ndig == 7'd1)
                                && (!left_r || pad_r == '0);
            P_RPAD: last_cond = (cnt_r + 7'd1 == pad_r);
            default: last_cond = 1'b0;
          endcase
          if (phase_r == P_BODY)
            nph = (op_r == OP_CHAR || sts.ndig == 7'd1) ? P_RPAD : P_BODY;
          else if (phase_r == P_RPAD || phase_r == P_LPAD || phase_r == P_ZPAD)
            nph = (cnt_r + 7'd1 >= pad_r) ? after(phase_r, op_r, left_r, has_sign)
                                           : phase_r;
          else
            nph = after(phase_r, op_r, left_r, has_sign);
          if (nph != phase_r) cnt_nxt = '0;
          phase_nxt = nph;
          ov_nxt    = 1'b1;
          olast_nxt = last_cond;
          if (last_cond) state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    phase_r <= phase_nxt;
    pad_r   <= pad_nxt;
    cnt_r   <= cnt_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
    if (req.valid && req.ready) begin
      op_r    <= req.opcode;
      left_r  <= req.left_align;
      plus_r  <= req.force_plus;
      zero_r  <= req.zero_fill;
      space_r <= req.space_sign;
      width_r <= req.field_width;
      char_r  <= req.value[7:0];
    end
  end

  assign chr.valid    = ov_r;
  assign chr.out_char = och_r;
  assign chr.is_last  = olast_r;

`ifndef SYNTHESIS
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free) else $error("word overwritten");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_cond) |=> state_r == S_IDLE) else $error("field not closed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !chr.ready) |=> ov_r && $stable(och_r)) else $error("word dropped");
`endif
endmodule

// File: tb/sv/integer_printf_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_printf_formatter_test: self-checking bench for the integer formatter
// Drives conversion requests with random idling, predicts each field's
// characters and compares every output word, including a long receiver stall.
// ----------------------------------------------------------------------------
module integer_printf_formatter_test;
  import ipf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } chr_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  ipf_req_if req ();
  ipf_chr_if chr ();

  integer_printf_formatter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req),
    .out_chr (chr)
  );

  chr_word_t field_q[$];
  int        n_errors = 0;
  int        cycle_cnt = 0;
  bit        no_idle = 1'b0;
  bit        hold_on = 1'b0;
  int        stall_left = 0;

  // Builds the expected characters of one field.
  task automatic format_field(input logic [2:0] op, input logic [63:0] val,
                              input bit wide, input bit left, input bit plus,
                              input bit zero, input bit spc, input logic [6:0] fw);
    logic [7:0]  body[$];
    logic [7:0]  rev[$];
    logic [7:0]  sign;
    logic [63:0] v;
    int          base;
    int          w;
    int          pad;
    logic [7:0]  chars[$];
    bit          upper;
    v = val;
    sign = 8'h00;
    base = 10;
    upper = 1'b0;
    case (op)
      OP_SDEC: begin
        if (!wide) v = {{32{val[31]}}, val[31:0]};
        if (v[63]) begin
          v = -v;
          sign = CH_MINUS;
        end else if (plus) sign = CH_PLUS;
        else if (spc) sign = CH_SPACE;
      end
      OP_UDEC: if (!wide) v = {32'd0, v[31:0]};
      OP_HEXL, OP_HEXU: begin
        if (!wide) v = {32'd0, v[31:0]};
        base = 16;
        upper = (op == OP_HEXU);
      end
      OP_OCT: begin
        if (!wide) v = {32'd0, v[31:0]};
        base = 8;
      end
      OP_BIN: begin
        if (!wide) v = {32'd0, v[31:0]};
        base = 2;
      end
      OP_PTR: begin
        base = 16;
        body.push_back(CH_ZERO);
        body.push_back(CH_X);
      end
      default: ;
    endcase
    if (op == OP_CHAR) body.push_back(val[7:0]);
    else begin
      if (v == 0) rev.push_back(CH_ZERO);
      while (v != 0) begin
        logic [3:0] d;
        d = 4'(v % base);
        rev.push_front(d < 10 ? CH_ZERO + d : (upper ? 8'h41 : 8'h61) + d - 8'd10);
        v = v / base;
      end
      foreach (rev[i]) body.push_back(rev[i]);
    end
    w = (fw > 64) ? 64 : fw;
    pad = w - body.size() - (sign != 0);
    if (pad < 0) pad = 0;
    if (!left && !zero) repeat (pad) chars.push_back(CH_SPACE);
    if (sign != 0) chars.push_back(sign);
    if (!left && zero) repeat (pad) chars.push_back(CH_ZERO);
    foreach (body[i]) chars.push_back(body[i]);
    if (left) repeat (pad) chars.push_back(CH_SPACE);
    foreach (chars[i]) field_q.push_back('{chars[i], i == chars.size() - 1});
  endtask

  task automatic send_req(input logic [2:0] op, input logic [63:0] val, input bit wide,
                          input bit left, input bit plus, input bit zero, input bit spc,
                          input logic [6:0] fw);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.value <= val;
    req.is_wide <= wide;
    req.left_align <= left;
    req.force_plus <= plus;
    req.zero_fill <= zero;
    req.space_sign <= spc;
    req.field_width <= fw;
    do @(posedge clk); while (!req.ready);
    format_field(op, val, wide, left, plus, zero, spc, fw);
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: return {32'hFFFFFFFF, $urandom};
      3: return {$urandom, 32'h0} | 64'(-$urandom_range(0, 3));
      default: return 64'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [6:0] fw;
    fw = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(65, 127)) :
         7'($urandom_range(0, 30));
    send_req(3'($urandom), rand_value(), 1'($urandom), 1'($urandom), 1'($urandom),
             1'($urandom), 1'($urandom), fw);
  endtask

  task automatic test_directed();
    send_req(OP_SDEC, 64'h0, 0, 0, 0, 0, 0, 0);
    send_req(OP_SDEC, 64'h8000_0000, 0, 0, 0, 1, 0, 15);
    send_req(OP_SDEC, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0, 0);
    send_req(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 1, 0, 1, 24);
    send_req(OP_SDEC, 64'd42, 0, 0, 0, 0, 1, 6);
    send_req(OP_SDEC, 64'hFFFF_FFFF, 0, 1, 0, 1, 0, 7);
    send_req(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 1, 0, 1, 0);
    send_req(OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1, 0, 12);
    send_req(OP_HEXL, 64'hDEAD_BEEF_CAFE_F00D, 1, 0, 0, 0, 0, 20);
    send_req(OP_HEXU, 64'hDEAD_BEEF_CAFE_F00D, 0, 1, 0, 0, 0, 12);
    send_req(OP_OCT, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 1, 0, 30);
    send_req(OP_BIN, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 64);
    send_req(OP_BIN, 64'h0, 0, 0, 0, 1, 0, 127);
    send_req(OP_CHAR, 64'h0, 0, 0, 0, 0, 0, 0);
    send_req(OP_CHAR, 64'hFF, 1, 1, 1, 1, 1, 5);
    send_req(OP_PTR, 64'h0, 0, 0, 0, 0, 0, 0);
    send_req(OP_PTR, 64'h1234_5678_9ABC_DEF0, 0, 0, 0, 1, 0, 24);
    send_req(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, 0, 0, 65);
    send_req(OP_SDEC, 64'h1, 0, 0, 1, 1, 1, 100);
  endtask

  task automatic test_random();
    repeat (61) send_random();
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (10) send_random();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    repeat (20) send_random();
  endtask

  // output side: ready pattern with random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      chr.ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_on) chr.ready <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      chr.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      chr.ready <= 1'b0;
    end else chr.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && chr.valid && chr.ready) begin
      if (field_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual char %02h last %0b",
                 $time, chr.out_char, chr.is_last);
        n_errors++;
      end else begin
        chr_word_t e;
        e = field_q.pop_front();
        if (e.ch !== chr.out_char || e.last !== chr.is_last) begin
          $display("%0t: mismatch: expected char %02h last %0b, actual char %02h last %0b",
                   $time, e.ch, e.last, chr.out_char, chr.is_last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 2_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.opcode = OP_SDEC;
    req.value = '0;
    req.is_wide = 1'b0;
    req.left_align = 1'b0;
    req.force_plus = 1'b0;
    req.zero_fill = 1'b0;
    req.space_sign = 1'b0;
    req.field_width = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    req.valid <= 1'b0;
    while (field_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && field_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: integer_printf_formatter.f
rtl/ipf_pkg.sv
rtl/ipf_if.sv
rtl/ipf_datapath.sv
rtl/ipf_ctrl.sv
rtl/integer_printf_formatter.sv
tb/sv/integer_printf_formatter_test.sv
